### src/execution_trace_recorder_top_macros.svh
// Assertion macros for the execution trace recorder.
// Included by every RTL file that carries concurrent assertions.
`ifndef EXECUTION_TRACE_RECORDER_TOP_MACROS_SVH
`define EXECUTION_TRACE_RECORDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ETR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("execution trace recorder: assertion failed");
// Expression must never be true outside reset.
`define ETR_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ETR_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define ETR_ASSERT(lbl, clk, rst_n, prop)
`define ETR_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### src/etr_pkg.sv
// Shared types, constants and record helpers of the execution trace recorder.
// No dependencies; used by every module of the block except etr_ram.
`default_nettype none

package etr_pkg;

  // Sizing (ring depth must be a power of two)
  localparam int RING_DEPTH   = 256;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int THREAD_SLOTS = 8;
  localparam int TID_W        = $clog2(THREAD_SLOTS + 1);
  localparam int TIDX_W       = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_EXT_W    = 16;

  // Event kinds
  localparam logic [2:0] KIND_THREAD_ENTER = 3'd0;
  localparam logic [2:0] KIND_THREAD_EXIT  = 3'd1;
  localparam logic [2:0] KIND_IRQ_ENTER    = 3'd2;
  localparam logic [2:0] KIND_IRQ_EXIT     = 3'd3;
  localparam logic [2:0] KIND_HANDLER      = 3'd4;
  localparam logic [2:0] KIND_ARM          = 3'd5;
  localparam logic [2:0] KIND_READ         = 3'd6;
  localparam logic [2:0] KIND_IGNORE       = 3'd7;

  // Record entity kinds
  localparam logic [1:0] REC_IRQ     = 2'd0;
  localparam logic [1:0] REC_THREAD  = 2'd1;
  localparam logic [1:0] REC_HANDLER = 2'd2;

  // Stop reasons
  localparam logic [1:0] STOP_PREEMPT = 2'd0;
  localparam logic [1:0] STOP_BLOCK   = 2'd1;
  localparam logic [1:0] STOP_YIELD   = 2'd2;
  localparam logic [1:0] STOP_EXIT    = 2'd3;

  // Thread states with a dedicated reason
  localparam logic [3:0] TSTATE_READY     = 4'd0;
  localparam logic [3:0] TSTATE_COMPLETED = 4'd1;
  localparam logic [3:0] TSTATE_TERMINATED = 4'd2;
  localparam logic [3:0] TSTATE_YIELDED   = 4'd4;

  localparam logic [15:0] DUR_MAX = 16'hFFFF;

  // Classified event word between front and back
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] time_us;
    logic [13:0] ident;
    logic [1:0]  reason;
    logic [31:0] duration;
    logic [7:0]  read_index;
    logic [8:0]  read_max;
  } cmd_t;

  function automatic logic [1:0] stop_reason(input logic [3:0] st);
    logic [1:0] r;
    case (st)
      TSTATE_READY:      r = STOP_PREEMPT;
      TSTATE_YIELDED:    r = STOP_YIELD;
      TSTATE_COMPLETED:  r = STOP_EXIT;
      TSTATE_TERMINATED: r = STOP_EXIT;
      default:           r = STOP_BLOCK;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic [31:0] d);
    return (d[31:16] != 16'd0) ? DUR_MAX : d[15:0];
  endfunction

  function automatic logic [63:0] pack_record(input logic [1:0]  rk,
                                              input logic [13:0] id,
                                              input logic [7:0]  info,
                                              input logic [31:0] start,
                                              input logic [15:0] dur);
    return {dur, start[23:0], info, rk, id};
  endfunction

endpackage

`default_nettype wire

### src/etr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module etr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/etr_front.sv
// Front end: accepts events, maps thread handles to ids, classifies words.
// Depends on etr_pkg and the assertion macro header.
`default_nettype none
`include "execution_trace_recorder_top_macros.svh"

module etr_front import etr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [31:0] time_us_i,
  input  wire logic [31:0] thread_handle_i,
  input  wire logic [3:0]  thread_state_i,
  input  wire logic [13:0] ident_i,
  input  wire logic [31:0] interval_duration_i,
  input  wire logic [7:0]  read_index_i,
  input  wire logic [8:0]  read_max_i,
  output logic             q_push_o,
  output cmd_t             q_cmd_o,
  input  wire logic        q_full_i
);

  logic [31:0]       table_q [THREAD_SLOTS];
  logic [TID_W-1:0]  used_q;
  logic [TID_W-1:0]  used_d;
  logic              found;
  logic [TID_W-1:0]  hit_id;
  logic              alloc;
  logic              mapped;
  logic [TID_W-1:0]  map_id;
  logic              accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  // Handle lookup over the filled slots
  always_comb begin
    found  = 1'b0;
    hit_id = '0;
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      if (!found && (TID_W'(i) < used_q) && (table_q[i] == thread_handle_i)) begin
        found  = 1'b1;
        hit_id = TID_W'(i + 1);
      end
    end
  end

  // Id assignment: existing slot, new slot, or none
  always_comb begin
    alloc  = 1'b0;
    mapped = 1'b0;
    map_id = hit_id;
    if (thread_handle_i != 32'd0) begin
      if (found) begin
        mapped = 1'b1;
      end else if (used_q < TID_W'(THREAD_SLOTS)) begin
        alloc  = 1'b1;
        mapped = 1'b1;
        map_id = used_q + TID_W'(1);
      end
    end
  end

  // Classified word; an unmapped thread exit becomes a no-op
  always_comb begin
    q_cmd_o.kind       = kind_i;
    q_cmd_o.time_us    = time_us_i;
    q_cmd_o.ident      = ident_i;
    q_cmd_o.reason     = stop_reason(thread_state_i);
    q_cmd_o.duration   = interval_duration_i;
    q_cmd_o.read_index = read_index_i;
    q_cmd_o.read_max   = read_max_i;
    if (kind_i == KIND_THREAD_EXIT) begin
      q_cmd_o.ident = 14'(map_id);
      if (!mapped) begin
        q_cmd_o.kind = KIND_IGNORE;
      end
    end
  end

  assign used_d = (accept && (kind_i == KIND_THREAD_EXIT) && alloc) ?
                  used_q + TID_W'(1) : used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  // Table entries carry no reset; only slots below the fill count are matched
  always_ff @(posedge clk_i) begin
    if (accept && (kind_i == KIND_THREAD_EXIT) && alloc) begin
      table_q[used_q[TIDX_W-1:0]] <= thread_handle_i;
    end
  end

  `ETR_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= TID_W'(THREAD_SLOTS))

endmodule

`default_nettype wire

### src/etr_queue.sv
// Short FIFO of classified event words between front and back.
// Depends on etr_pkg and the assertion macro header.
`default_nettype none
`include "execution_trace_recorder_top_macros.svh"

module etr_queue import etr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      pop_data_o,
  output logic      empty_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ETR_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= QCNT_W'(QUEUE_DEPTH))
  `ETR_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && empty_o)

endmodule

`default_nettype wire

### src/etr_back.sv
// Back end: timing state, record packing, trace ring access, output register.
// Depends on etr_pkg, etr_ram and the assertion macro header.
`default_nettype none
`include "execution_trace_recorder_top_macros.svh"

module etr_back import etr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_empty_i,
  input  cmd_t             q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             pushed_o,
  output logic [63:0]      record_word_o,
  output logic             read_valid_o,
  output logic [8:0]       available_count_o,
  output logic [31:0]      total_pushed_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]         state_q;
  cmd_t               cmd_q;

  // Tracer state
  logic [31:0]        push_count_q;
  logic [RING_AW-1:0] wr_ptr_q;
  logic [31:0]        slice_start_q;
  logic [31:0]        slice_irq_q;
  logic [31:0]        irq_start_q;
  logic [8:0]         irq_vector_q;

  // Step results
  logic [31:0]        diff_q;
  logic [8:0]         win_n_q;
  logic               win_hit_q;
  logic               res_pushed_q;
  logic [63:0]        res_word_q;
  logic               res_rvalid_q;
  logic [8:0]         res_avail_q;

  // Output register
  logic               out_valid_q;
  logic               out_pushed_q;
  logic [63:0]        out_word_q;
  logic               out_rvalid_q;
  logic [8:0]         out_avail_q;
  logic [31:0]        out_total_q;

  logic [31:0]        pc_cap;
  logic [8:0]         win_n;
  logic               win_hit;
  logic [RING_AW-1:0] rd_pos;
  logic [31:0]        diff_d;
  logic               ram_re;
  logic [63:0]        ram_rdata;
  logic [31:0]        thr_d;
  logic               fin_push;
  logic [63:0]        fin_word;
  logic               fin_rvalid;
  logic [8:0]         fin_avail;
  logic               out_load;

  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Compute step: window size, ring position, elapsed time
  always_comb begin
    pc_cap  = (push_count_q > 32'(RING_DEPTH)) ? 32'(RING_DEPTH) : push_count_q;
    win_n   = (pc_cap > {23'd0, cmd_q.read_max}) ? cmd_q.read_max : pc_cap[8:0];
    win_hit = ({1'b0, cmd_q.read_index} < win_n);
    rd_pos  = RING_AW'(PTR_EXT_W'(wr_ptr_q) + PTR_EXT_W'(cmd_q.read_index)
                       - PTR_EXT_W'(win_n));
    diff_d  = (cmd_q.kind == KIND_THREAD_EXIT) ? cmd_q.time_us - slice_start_q
                                               : cmd_q.time_us - irq_start_q;
  end

  assign ram_re = (state_q == ST_CALC) && (cmd_q.kind == KIND_READ) && win_hit;

  // Finish step: record packing and read result
  always_comb begin
    thr_d      = (diff_q > slice_irq_q) ? diff_q - slice_irq_q : 32'd0;
    fin_push   = 1'b0;
    fin_word   = 64'd0;
    fin_rvalid = 1'b0;
    fin_avail  = 9'd0;
    case (cmd_q.kind)
      KIND_THREAD_EXIT: begin
        fin_push = 1'b1;
        fin_word = pack_record(REC_THREAD, cmd_q.ident, {6'd0, cmd_q.reason},
                               slice_start_q, sat16(thr_d));
      end
      KIND_IRQ_EXIT: begin
        fin_push = 1'b1;
        fin_word = pack_record(REC_IRQ, {5'd0, irq_vector_q}, 8'd0,
                               irq_start_q, sat16(diff_q));
      end
      KIND_HANDLER: begin
        fin_push = 1'b1;
        fin_word = pack_record(REC_HANDLER, cmd_q.ident, 8'd0,
                               cmd_q.time_us, sat16(cmd_q.duration));
      end
      KIND_READ: begin
        fin_rvalid = win_hit_q;
        fin_avail  = win_n_q;
        fin_word   = win_hit_q ? ram_rdata : 64'd0;
      end
      default: begin
        fin_push = 1'b0;
      end
    endcase
  end

  etr_ram #(
    .WIDTH (64),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_FIN) && fin_push),
    .waddr_i (wr_ptr_q),
    .wdata_i (fin_word),
    .re_i    (ram_re),
    .raddr_i (rd_pos),
    .rdata_o (ram_rdata)
  );

  // Sequencer and tracer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      push_count_q  <= '0;
      wr_ptr_q      <= '0;
      slice_start_q <= '0;
      slice_irq_q   <= '0;
      irq_start_q   <= '0;
      irq_vector_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          state_q <= ST_OUT;
          if (fin_push) begin
            push_count_q <= push_count_q + 32'd1;
            wr_ptr_q     <= wr_ptr_q + RING_AW'(1);
          end
          case (cmd_q.kind)
            KIND_THREAD_ENTER: begin
              slice_start_q <= cmd_q.time_us;
              slice_irq_q   <= '0;
            end
            KIND_IRQ_ENTER: begin
              irq_vector_q <= cmd_q.ident[8:0];
              irq_start_q  <= cmd_q.time_us;
            end
            KIND_IRQ_EXIT: begin
              slice_irq_q <= slice_irq_q + diff_q;
            end
            KIND_ARM: begin
              push_count_q <= '0;
              wr_ptr_q     <= '0;
            end
            default: begin
              slice_irq_q <= slice_irq_q;
            end
          endcase
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Per-item payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
    end
    if (state_q == ST_CALC) begin
      diff_q    <= diff_d;
      win_n_q   <= win_n;
      win_hit_q <= win_hit;
    end
    if (state_q == ST_FIN) begin
      res_pushed_q <= fin_push;
      res_word_q   <= fin_word;
      res_rvalid_q <= fin_rvalid;
      res_avail_q  <= fin_avail;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pushed_q <= res_pushed_q;
      out_word_q   <= res_word_q;
      out_rvalid_q <= res_rvalid_q;
      out_avail_q  <= res_avail_q;
      out_total_q  <= push_count_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pushed_o          = out_pushed_q;
  assign record_word_o     = out_word_q;
  assign read_valid_o      = out_rvalid_q;
  assign available_count_o = out_avail_q;
  assign total_pushed_o    = out_total_q;

  `ETR_ASSERT(a_push_counts, clk_i, rst_ni, (state_q == ST_FIN) && fin_push |=> push_count_q == $past(push_count_q) + 32'd1)
  `ETR_ASSERT(a_read_in_window, clk_i, rst_ni, out_load && res_rvalid_q |-> res_avail_q != 9'd0)
  `ETR_ASSERT_NEVER(a_push_xor_read, clk_i, rst_ni, out_load && res_pushed_q && res_rvalid_q)

endmodule

`default_nettype wire

### src/execution_trace_recorder_top.sv
// Execution trace recorder: scheduler event tracer with a record ring.
// Input channel: one event word per handshake (kind, time, handle, state,
//   ident, interval, read index, read maximum), valid/ready.
// Output channel: exactly one result word per event (pushed flag, 8-byte
//   record, read valid, available count, total pushed), valid/ready.
// The front maps thread handles to ids and classifies each event into a
//   two-entry queue; the back sequencer steps each event through dequeue,
//   time/window compute, ring write or ring read, and output load.
// The back takes a new event only once the last result is loaded into the
//   output register; the queue accepts new events meanwhile. An event is
//   held in turn in the queue, command, step result and output registers.
// Reset clears the counters, the thread fill count and timing state; the
//   ring and thread table hold no reset value and are never read unwritten.
// While the receiver stalls, the held result waits in the output register,
//   the back stops and the queue fills; input ready drops when it is full.
// Depends on etr_pkg, etr_front, etr_queue and etr_back.
`default_nettype none

module execution_trace_recorder_top import etr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [31:0] time_us_i,
  input  wire logic [31:0] thread_handle_i,
  input  wire logic [3:0]  thread_state_i,
  input  wire logic [13:0] ident_i,
  input  wire logic [31:0] interval_duration_i,
  input  wire logic [7:0]  read_index_i,
  input  wire logic [8:0]  read_max_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             pushed_o,
  output logic [63:0]      record_word_o,
  output logic             read_valid_o,
  output logic [8:0]       available_count_o,
  output logic [31:0]      total_pushed_o
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_in;
  cmd_t q_out;

  etr_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .kind_i              (kind_i),
    .time_us_i           (time_us_i),
    .thread_handle_i     (thread_handle_i),
    .thread_state_i      (thread_state_i),
    .ident_i             (ident_i),
    .interval_duration_i (interval_duration_i),
    .read_index_i        (read_index_i),
    .read_max_i          (read_max_i),
    .q_push_o            (q_push),
    .q_cmd_o             (q_in),
    .q_full_i            (q_full)
  );

  etr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_out),
    .empty_o     (q_empty)
  );

  etr_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_cmd_i           (q_out),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pushed_o          (pushed_o),
    .record_word_o     (record_word_o),
    .read_valid_o      (read_valid_o),
    .available_count_o (available_count_o),
    .total_pushed_o    (total_pushed_o)
  );

endmodule

`default_nettype wire
